// File: hdl/scs_pkg.sv
// shared types and constants for the sorted cell set
package scs_pkg;

	// field widths of the items
	localparam int CODE_W  = 16;
	localparam int COUNT_W = 6;
	localparam int OP_W    = 2;

	// operation codes carried in s_tuser
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef logic [CODE_W-1:0] code_t;

	// compare flags reported by one cell
	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

// File: hdl/scs_cell.sv
// one slot of the sorted chain: holds a code, compares it, shifts up on insert
module scs_cell (
	input  logic                 clk,
	input  logic                 occupied,
	input  logic                 insert,
	input  scs_pkg::code_t       code,
	input  scs_pkg::code_t       prev_entry,
	input  logic                 prev_lt,
	output scs_pkg::code_t       entry,
	output scs_pkg::cell_flags_t flags
);
	import scs_pkg::*;

	code_t entry_q;

	// compare the held code against the requested one
	always_comb begin
		flags.lt = occupied && (entry_q < code);
		flags.eq = occupied && (entry_q == code);
	end

	// on insert, the slot at the insertion point takes the new code,
	// slots above it take the neighbor's code, slots below keep theirs
	always_ff @(posedge clk) begin
		if (insert && !flags.lt) begin
			entry_q <= prev_lt ? code : prev_entry;
		end
	end

	assign entry = entry_q;

endmodule

// File: hdl/sorted_cell_set_unit.sv
// Sorted cell set: a bounded, ascending, duplicate-free set of 16-bit cell codes held in a
// chain of CAPACITY cells. Each item on the slave side carries an operation in s_tuser
// (clear, add, query) and a cell code in s_tdata; each produces exactly one result item
// with ok, the element count after the operation and the sticky truncated flag. Every
// cell compares its code with the request in parallel; the cell count, a hit OR over all
// cells and the shift of the chain on insert are settled at the accepting clock edge, so
// the block takes one item per cycle while s_tready is high. Results sit in an output
// register; s_tready is high whenever that register is empty or being drained, so a result
// waiting on m_tready does not stop the next item as long as it is taken in the same cycle.
module sorted_cell_set_unit #(
	parameter int CAPACITY = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] cell_req
	input  logic [1:0]  s_tuser,   // [1:0] op
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] ok, [6:1] count, [7] truncated
);
	import scs_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          trunc_q;
	logic          out_valid_q;
	logic          ok_q;
	logic [COUNT_W-1:0] count_out_q;
	logic          trunc_out_q;

	code_t         entries   [CAPACITY];
	cell_flags_t   flags     [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;

	op_t           op;
	code_t         code;
	logic          accept;
	logic          found;
	logic          full;
	logic          insert;
	logic          ok_d;
	logic [CW-1:0] count_d;
	logic          trunc_d;
	logic [CW+COUNT_W-1:0] count_ext;

	assign op     = op_t'(s_tuser);
	assign code   = s_tdata;
	assign accept = s_tvalid && s_tready;
	assign full   = (count_q == CW'(CAPACITY));
	assign found  = |hit_vec;

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   prev_lt;
		code_t  prev_entry;
		if (i == 0) begin : g_first
			assign prev_lt    = 1'b1;
			assign prev_entry = code;
		end else begin : g_rest
			assign prev_lt    = flags[i-1].lt;
			assign prev_entry = entries[i-1];
		end
		scs_cell u_cell (
			.clk        (clk),
			.occupied   (CW'(i) < count_q),
			.insert     (insert),
			.code       (code),
			.prev_entry (prev_entry),
			.prev_lt    (prev_lt),
			.entry      (entries[i]),
			.flags      (flags[i])
		);
		assign hit_vec[i] = flags[i].eq;
	end

	// operation decode and next set state
	always_comb begin
		insert  = 1'b0;
		ok_d    = 1'b0;
		count_d = count_q;
		trunc_d = trunc_q;
		unique case (op)
			OP_CLEAR: begin
				ok_d    = 1'b1;
				count_d = '0;
				trunc_d = 1'b0;
			end
			OP_ADD: begin
				if (found) begin
					ok_d = 1'b1;
				end else if (full) begin
					trunc_d = 1'b1;
				end else begin
					ok_d    = 1'b1;
					insert  = accept;
					count_d = count_q + 1'b1;
				end
			end
			OP_QUERY: begin
				ok_d = found;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	// set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			trunc_q <= 1'b0;
		end else if (accept) begin
			count_q <= count_d;
			trunc_q <= trunc_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q        <= ok_d;
			count_out_q <= count_ext[COUNT_W-1:0];
			trunc_out_q <= trunc_d;
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {trunc_out_q, count_out_q, ok_q};

	// the set never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("cell count above capacity");

	// a clear empties the set and drops the flag
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_CLEAR) |=> (count_q == '0 && !trunc_q))
		else $error("clear did not empty the set");

	// a refused add raises the sticky flag and leaves the count
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_ADD && full && !found) |=>
		(trunc_q && $stable(count_q) && !ok_q))
		else $error("refused add handled wrongly");

	// a new code added below capacity grows the count by one
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_ADD && !full && !found) |=>
		(count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the set");

endmodule
